FILE: rtl/bsst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsst_pkg;

	localparam int CNT_W = 11;
	localparam int VAL_W = 32;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_REVERSED = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic check;
		logic decide;
		logic init;
		logic shift;
		logic place;
		logic bottom;
		logic load_out;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic reject;
		logic empty;
		logic above;
		logic idx_zero;
		logic rem_zero;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bsst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bsst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bsst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsst_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire bsst_pkg::dp_stat_t  stat,
	output bsst_pkg::dp_cmd_t        cmd,
	output logic                     busy,
	output logic                     done
);

	import bsst_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CHECK  = 7'b0000010,
		ST_DECIDE = 7'b0000100,
		ST_INIT   = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_BOTTOM = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	// sequence one item: check, decide, then insert value by value
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.reject ? ST_RESULT : ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = stat.empty ? ST_BOTTOM : ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.above) begin
					cmd.shift = 1'b1;
					state_d   = stat.idx_zero ? ST_BOTTOM : ST_SCAN;
				end else begin
					cmd.place = 1'b1;
					state_d   = stat.rem_zero ? ST_RESULT : ST_INIT;
				end
			end
			ST_BOTTOM: begin
				cmd.bottom = 1'b1;
				state_d    = stat.rem_zero ? ST_RESULT : ST_INIT;
			end
			ST_RESULT: begin
				cmd.load_out = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// advance state; done is registered from the result state, so it rises together with the loaded result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_RESULT);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

FILE: rtl/bsst_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bsst_dp #(
	parameter int unsigned STORE_DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bsst_pkg::dp_cmd_t                 cmd,
	output bsst_pkg::dp_stat_t                     stat,
	input  wire logic                              cfg_wr_en,
	input  wire logic        [bsst_pkg::CNT_W-1:0] cfg_wr_data,
	input  wire logic                              opcode,
	input  wire logic signed [bsst_pkg::VAL_W-1:0] first_value,
	input  wire logic signed [bsst_pkg::VAL_W-1:0] last_value,
	output logic             [1:0]                 status,
	output logic                                   span_valid,
	output logic             [bsst_pkg::VAL_W-1:0] shortest_span,
	output logic             [bsst_pkg::VAL_W-1:0] longest_span,
	output logic             [bsst_pkg::CNT_W-1:0] stored_count
);

	import bsst_pkg::*;

	localparam int unsigned AW         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int unsigned CNT_MAX    = (1 << CNT_W) - 1;
	localparam int unsigned DEPTH_CLIP = (STORE_DEPTH < CNT_MAX) ? STORE_DEPTH : CNT_MAX;
	localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(DEPTH_CLIP);

	logic [CNT_W-1:0] cap_q;
	logic             op_q;
	logic [VAL_W-1:0] first_q, last_q;
	logic [VAL_W-1:0] len_q, rem_q, cur_q;
	logic             rev_q;
	logic [AW-1:0]    idx_q;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] smallest_q, largest_q;
	logic [VAL_W:0]   gap_q;
	status_t          status_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [VAL_W-1:0] out_short_q, out_long_q;
	logic [CNT_W-1:0] out_count_q;

	logic [CNT_W-1:0] cap_eff;
	logic             over;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;
	logic             above;
	logic [VAL_W-1:0] abs_diff;
	logic [VAL_W:0]   gap_next;
	logic             commit;

	// clip the capacity to the store depth and test the run against it
	assign cap_eff = (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q;
	assign over    = ({1'b0, len_q} + (VAL_W + 1)'(count_q)) >= (VAL_W + 1)'(cap_eff);

	// compare the entry read back with the value being inserted
	assign above    = ram_rdata > cur_q;
	assign abs_diff = above ? (ram_rdata - cur_q) : (cur_q - ram_rdata);
	assign gap_next = ({1'b0, abs_diff} < gap_q) ? {1'b0, abs_diff} : gap_q;
	assign commit   = cmd.place | cmd.bottom;

	assign stat.reject   = rev_q | over;
	assign stat.empty    = (count_q == '0);
	assign stat.above    = above;
	assign stat.idx_zero = (idx_q == '0);
	assign stat.rem_zero = (rem_q == '0);

	// walk the store downward, moving larger entries up by one
	assign ram_re    = cmd.init | cmd.shift;
	assign ram_raddr = cmd.init ? AW'(count_q - CNT_W'(1)) : (idx_q - AW'(1));
	assign ram_we    = cmd.shift | cmd.place | cmd.bottom;
	assign ram_waddr = cmd.bottom ? '0 : (idx_q + AW'(1));
	assign ram_wdata = cmd.shift ? ram_rdata : cur_q;

	bsst_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// hold the capacity and the set summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= '0;
			count_q    <= '0;
			smallest_q <= '0;
			largest_q  <= '0;
			gap_q      <= '1;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.shift || cmd.place) begin
				gap_q <= gap_next;
			end
			if (commit) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q == '0) begin
					smallest_q <= cur_q;
					largest_q  <= cur_q;
				end else begin
					if (cur_q < smallest_q) begin
						smallest_q <= cur_q;
					end
					if (cur_q >= largest_q) begin
						largest_q <= cur_q;
					end
				end
			end
		end
	end

	// latch the item in sign-biased form and step through the run
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= opcode;
			first_q <= {~first_value[VAL_W-1], first_value[VAL_W-2:0]};
			last_q  <= {~last_value[VAL_W-1], last_value[VAL_W-2:0]};
		end
		if (cmd.check) begin
			rev_q <= op_q & (last_q < first_q);
			len_q <= op_q ? (last_q - first_q) : '0;
		end
		if (cmd.decide) begin
			if (rev_q) begin
				status_q <= STATUS_REVERSED;
			end else if (over) begin
				status_q <= STATUS_FULL;
			end else begin
				status_q <= STATUS_OK;
			end
			rem_q <= len_q;
			cur_q <= first_q;
		end
		if (cmd.init) begin
			idx_q <= AW'(count_q - CNT_W'(1));
		end
		if (cmd.shift) begin
			idx_q <= idx_q - AW'(1);
		end
		if (commit) begin
			cur_q <= cur_q + VAL_W'(1);
			rem_q <= rem_q - VAL_W'(1);
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_count_q  <= count_q;
			out_valid_q  <= (count_q >= CNT_W'(2));
			if (count_q >= CNT_W'(2)) begin
				out_short_q <= gap_q[VAL_W-1:0];
				out_long_q  <= largest_q - smallest_q;
			end else begin
				out_short_q <= '0;
				out_long_q  <= '0;
			end
		end
	end

	assign status        = out_status_q;
	assign span_valid    = out_valid_q;
	assign shortest_span = out_short_q;
	assign longest_span  = out_long_q;
	assign stored_count  = out_count_q;

endmodule

`default_nettype wire

FILE: rtl/bounded_set_span_tracker.sv
// A rejected item passes the check, decide and result states before its done strobe; an item
// that adds values also, for each added value, reads the top entry and shifts up every held
// value greater than it before writing the value in (the sorted store is scanned top down).
// Throughput: one item at a time; busy stays high until the result is loaded.
// The result is shown with done, which is high for a single cycle and cannot be stalled.
// Reset (arst_n low) empties the set and clears the capacity; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_set_span_tracker #(
	parameter int unsigned STORE_DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic        [bsst_pkg::CNT_W-1:0] cfg_wr_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              opcode,
	input  wire logic signed [bsst_pkg::VAL_W-1:0] first_value,
	input  wire logic signed [bsst_pkg::VAL_W-1:0] last_value,
	output logic                                   done,
	output logic             [1:0]                 status,
	output logic                                   span_valid,
	output logic             [bsst_pkg::VAL_W-1:0] shortest_span,
	output logic             [bsst_pkg::VAL_W-1:0] longest_span,
	output logic             [bsst_pkg::CNT_W-1:0] stored_count
);

	import bsst_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bsst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bsst_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.first_value   (first_value),
		.last_value    (last_value),
		.status        (status),
		.span_valid    (span_valid),
		.shortest_span (shortest_span),
		.longest_span  (longest_span),
		.stored_count  (stored_count)
	);

endmodule

`default_nettype wire

FILE: rtl/bsst_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module bsst_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       done,
	input wire logic [1:0]                 status,
	input wire logic                       span_valid,
	input wire logic [bsst_pkg::VAL_W-1:0] shortest_span,
	input wire logic [bsst_pkg::VAL_W-1:0] longest_span,
	input wire logic [bsst_pkg::CNT_W-1:0] stored_count
);

	import bsst_pkg::*;

	// an accepted transfer keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// the result appears only once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// no two results in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// span flag follows the count, and invalid spans read zero
	a_span_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (span_valid == (stored_count >= CNT_W'(2))))
		else $error("span_valid does not match stored_count");

	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !span_valid |-> (shortest_span == '0) && (longest_span == '0)
			&& (status != STATUS_REVERSED || stored_count < CNT_W'(2)))
		else $error("spans not zero while invalid");

endmodule

bind bounded_set_span_tracker bsst_chk u_bsst_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.span_valid    (span_valid),
	.shortest_span (shortest_span),
	.longest_span  (longest_span),
	.stored_count  (stored_count)
);

`default_nettype wire
